>>> rtl/rfa_pkg.sv
// Package for the rational fraction ALU: operation and fault codes, sequencer
// states and shared width constants. No dependencies.
package rfa_pkg;

   localparam int DATA_W            = 64;
   localparam int OP_W              = 3;
   localparam int FAULT_W           = 3;
   localparam int ORDER_W           = 2;
   localparam int LIMIT_W           = 21;
   localparam int VALUE_WIDTH_DEF   = 64;
   localparam int MAX_FACT_ARG_DEF  = 20;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1 << 20);

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_MOD  = 3'd4,
      OP_CMP  = 3'd5,
      OP_FACT = 3'd6
   } op_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE         = 3'd0,
      FAULT_ZERO_ZERO    = 3'd1,
      FAULT_NEG_DEN      = 3'd2,
      FAULT_MOD_NONINT   = 3'd3,
      FAULT_FACT_NONINT  = 3'd4,
      FAULT_FACT_RANGE   = 3'd5,
      FAULT_MOD_ZERO     = 3'd6
   } fault_type;

   localparam logic [ORDER_W-1:0] ORDER_EQ = 2'b00;
   localparam logic [ORDER_W-1:0] ORDER_GT = 2'b01;
   localparam logic [ORDER_W-1:0] ORDER_LT = 2'b11;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_MUL,
      S_DIV,
      S_M1,
      S_M2,
      S_M3,
      S_RED_BEGIN,
      S_RED_D1,
      S_RED_D2,
      S_RED_TWO,
      S_RED_TRIAL,
      S_RED_TA,
      S_RED_TB,
      S_RED_END,
      S_POST,
      S_MOD_END,
      S_FACT_LOOP,
      S_FACT_NEXT,
      S_DONE
   } state_type;

endpackage

>>> rtl/rfa_req_if.sv
// Request channel interface of the rational fraction ALU (valid/ready).
// Depends on rfa_pkg.
interface rfa_req_if;
   import rfa_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [DATA_W-1:0]   a_num;
   logic [DATA_W-1:0]   a_den;
   logic [DATA_W-1:0]   b_num;
   logic [DATA_W-1:0]   b_den;
   modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

>>> rtl/rfa_rsp_if.sv
// Response channel interface of the rational fraction ALU (valid/ready).
// Depends on rfa_pkg.
interface rfa_rsp_if;
   import rfa_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   res_num;
   logic [DATA_W-1:0]   res_den;
   logic [ORDER_W-1:0]  order;
   logic [FAULT_W-1:0]  fault;
   modport source (output valid, res_num, res_den, order, fault, input ready);
   modport sink   (input valid, res_num, res_den, order, fault, output ready);
endinterface

>>> rtl/rational_fraction_alu_top.sv
// Rational fraction ALU: add/sub/mul/div/mod/compare/factorial with reduction.
// Depends on rfa_pkg, rfa_req_if and rfa_rsp_if.
// A direct compare skips the shared shift/add unit; the other operations pass through it,
//   and reduction tries odd trial divisors, dividing both parts when one divides,
//   up to about reduction_limit/2 trials.
// One transaction in flight; the next is accepted after the result is taken. Reset:
//   synchronous, active high; returns to idle, reduction_limit = 1<<20.
module rational_fraction_alu_top #(
   parameter int VALUE_WIDTH       = rfa_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_FACTORIAL_ARG = rfa_pkg::MAX_FACT_ARG_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rfa_pkg::LIMIT_W-1:0] csr_wr_data,
   rfa_req_if.sink                     req_ch,
   rfa_rsp_if.source                   rsp_ch
);
   import rfa_pkg::*;

   localparam int W       = VALUE_WIDTH;
   localparam int K_W     = $clog2(MAX_FACTORIAL_ARG + 2);
   localparam int CMP_W   = (W > LIMIT_W) ? W : LIMIT_W;
   localparam int TRIAL_W = LIMIT_W + 1;
   localparam int CNT_W   = $clog2(W);

   // sequencer
   state_type state_ff, state_in, ret_ff, ret_in;

   // configuration
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // operands of the transaction
   op_type          op_ff, op_in;
   logic [W-1:0]    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;

   // result and reduction state
   logic [W-1:0]    rn_ff, rn_in, rd_ff, rd_in, p1_ff, p1_in;
   logic [W-1:0]    mn_ff, mn_in, md_ff, md_in, tq_ff, tq_in;
   logic            neg_ff, neg_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [TRIAL_W-1:0] trial_ff, trial_in;
   logic [K_W-1:0]  k_ff, k_in;
   fault_type       fault_ff, fault_in;
   logic [ORDER_W-1:0] order_ff, order_in;

   // shared shift/add unit: multiplicand/quotient, multiplier/divisor, acc/remainder
   logic [W-1:0]    ua_ff, ua_in, ub_ff, ub_in, uacc_ff, uacc_in;
   logic [CNT_W-1:0] ucnt_ff, ucnt_in;

   // ---------------- shared conditions ----------------
   logic            unit_last, rem_zero, both_even, trial_ok, fact_ok;
   logic [W-1:0]    rn_mag, bn_mag, bn_eff, red_min, half;
   logic [LIMIT_W-1:0] lim_calc;
   logic            cmp_direct;
   logic [ORDER_W-1:0] cmp_direct_order, cmp_prod_order;
   fault_type       post_fault;
   logic [W:0]      div_rem2, div_diff;
   logic            div_ge;

   assign unit_last = (ucnt_ff == CNT_W'(W - 1));
   assign rem_zero  = (uacc_ff == '0);
   assign both_even = ~mn_ff[0] & ~md_ff[0];
   assign rn_mag    = rn_ff[W-1] ? (W'(0) - rn_ff) : rn_ff;
   assign bn_mag    = bn_ff[W-1] ? (W'(0) - bn_ff) : bn_ff;
   assign bn_eff    = (op_ff == OP_SUB) ? (W'(0) - bn_ff) : bn_ff;
   assign red_min   = (mn_ff < md_ff) ? mn_ff : md_ff;
   assign half      = (red_min >> 1) + W'(1);
   assign lim_calc  = (CMP_W'(half) > CMP_W'(limit_ff)) ? limit_ff : LIMIT_W'(half);
   assign trial_ok  = trial_ff < {1'b0, lim_ff};
   assign fact_ok   = W'(k_ff) <= rn_ff;

   assign div_rem2  = {uacc_ff, ua_ff[W-1]};
   assign div_diff  = div_rem2 - {1'b0, ub_ff};
   assign div_ge    = div_rem2 >= {1'b0, ub_ff};

   // compare without products: denominators both one or both infinite, or one infinite
   always_comb begin
      cmp_direct       = 1'b1;
      cmp_direct_order = ORDER_EQ;
      if ((ad_ff == W'(1) && bd_ff == W'(1)) || (ad_ff == '0 && bd_ff == '0)) begin
         if ($signed(an_ff) > $signed(bn_ff))      cmp_direct_order = ORDER_GT;
         else if ($signed(an_ff) < $signed(bn_ff)) cmp_direct_order = ORDER_LT;
         else                                      cmp_direct_order = ORDER_EQ;
      end else if (ad_ff == '0) begin
         cmp_direct_order = ($signed(an_ff) > $signed(W'(0))) ? ORDER_GT : ORDER_LT;
      end else if (bd_ff == '0) begin
         cmp_direct_order = ($signed(bn_ff) > $signed(W'(0))) ? ORDER_LT : ORDER_GT;
      end else begin
         cmp_direct = 1'b0;
      end
   end

   assign cmp_prod_order = ($signed(p1_ff) > $signed(uacc_ff)) ? ORDER_GT :
                           ($signed(p1_ff) < $signed(uacc_ff)) ? ORDER_LT : ORDER_EQ;

   // operand checks once the first fraction is reduced
   always_comb begin
      post_fault = fault_ff;
      case (op_ff)
         OP_MOD: begin
            if (fault_ff == FAULT_NONE && (rd_ff != W'(1) || bd_ff != W'(1)))
               post_fault = FAULT_MOD_NONINT;
            else if (fault_ff == FAULT_NONE && bn_ff == '0)
               post_fault = FAULT_MOD_ZERO;
         end
         OP_FACT: begin
            if (fault_ff == FAULT_NONE && rd_ff != W'(1))
               post_fault = FAULT_FACT_NONINT;
            else if (fault_ff == FAULT_NONE &&
                     (rn_ff[W-1] || rn_ff > W'(MAX_FACTORIAL_ARG)))
               post_fault = FAULT_FACT_RANGE;
         end
         default: post_fault = fault_ff;
      endcase
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_IDLE:  if (req_ch.valid) state_in = S_START;
         S_START: begin
            case (op_ff)
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  state_in = S_MUL; ret_in = S_M1;
               end
               OP_CMP: begin
                  if (cmp_direct) state_in = S_DONE;
                  else begin state_in = S_MUL; ret_in = S_M1; end
               end
               OP_MOD, OP_FACT: state_in = S_RED_BEGIN;
               default: state_in = S_DONE;
            endcase
         end
         S_MUL, S_DIV: if (unit_last) state_in = ret_ff;
         S_M1: begin state_in = S_MUL; ret_in = S_M2; end
         S_M2: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin state_in = S_MUL; ret_in = S_M3; end
               OP_CMP: state_in = S_DONE;
               default: state_in = S_RED_BEGIN;
            endcase
         end
         S_M3: state_in = S_RED_BEGIN;
         S_RED_BEGIN: begin
            if (rd_ff[W-1] || rd_ff == '0) state_in = S_POST;
            else begin state_in = S_DIV; ret_in = S_RED_D1; end
         end
         S_RED_D1: begin
            if (rem_zero) state_in = S_RED_END;
            else begin state_in = S_DIV; ret_in = S_RED_D2; end
         end
         S_RED_D2: state_in = rem_zero ? S_RED_END : S_RED_TWO;
         S_RED_TWO: if (!both_even) state_in = S_RED_TRIAL;
         S_RED_TRIAL: begin
            if (trial_ok) begin state_in = S_DIV; ret_in = S_RED_TA; end
            else state_in = S_RED_END;
         end
         S_RED_TA: begin
            if (rem_zero) begin state_in = S_DIV; ret_in = S_RED_TB; end
            else state_in = S_RED_TRIAL;
         end
         S_RED_TB:  state_in = S_RED_TRIAL;
         S_RED_END: state_in = S_POST;
         S_POST: begin
            if (op_ff == OP_MOD && post_fault == FAULT_NONE) begin
               state_in = S_DIV; ret_in = S_MOD_END;
            end else if (op_ff == OP_FACT && post_fault == FAULT_NONE) begin
               state_in = S_FACT_LOOP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MOD_END: state_in = S_DONE;
         S_FACT_LOOP: begin
            if (fact_ok) begin state_in = S_MUL; ret_in = S_FACT_NEXT; end
            else state_in = S_DONE;
         end
         S_FACT_NEXT: state_in = S_FACT_LOOP;
         S_DONE: if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      logic [W-1:0] lx, ly;
      lx = '0;
      ly = '0;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      rn_in = rn_ff; rd_in = rd_ff; p1_in = p1_ff; mn_in = mn_ff; md_in = md_ff;
      tq_in = tq_ff; neg_in = neg_ff; lim_in = lim_ff; trial_in = trial_ff;
      k_in = k_ff; fault_in = fault_ff; order_in = order_ff;
      ua_in = ua_ff; ub_in = ub_ff; uacc_in = uacc_ff; ucnt_in = ucnt_ff;

      // operands for a unit launch, chosen by the launching state
      case (state_ff)
         S_START: begin lx = an_ff; ly = (op_ff == OP_MUL) ? bn_ff : bd_ff; end
         S_M1: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin lx = bn_eff; ly = ad_ff; end
               OP_MUL:         begin lx = ad_ff;  ly = bd_ff; end
               OP_DIV:         begin lx = ad_ff;  ly = bn_ff; end
               default:        begin lx = bn_ff;  ly = ad_ff; end
            endcase
         end
         S_M2:        begin lx = ad_ff;  ly = bd_ff; end
         S_RED_BEGIN: begin lx = rn_mag; ly = rd_ff; end
         S_RED_D1:    begin lx = md_ff;  ly = mn_ff; end
         S_RED_TRIAL: begin lx = mn_ff;  ly = W'(trial_ff); end
         S_RED_TA:    begin lx = md_ff;  ly = W'(trial_ff); end
         S_POST:      begin lx = rn_mag; ly = bn_mag; end
         S_FACT_LOOP: begin lx = p1_ff;  ly = W'(k_ff); end
         default:     begin lx = '0;     ly = '0; end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = op_type'(req_ch.op);
               an_in    = req_ch.a_num[W-1:0];
               ad_in    = req_ch.a_den[W-1:0];
               bn_in    = req_ch.b_num[W-1:0];
               bd_in    = req_ch.b_den[W-1:0];
               rn_in    = '0;
               rd_in    = W'(1);
               fault_in = FAULT_NONE;
               order_in = ORDER_EQ;
            end
         end
         S_START: begin
            if (op_ff == OP_CMP && cmp_direct) order_in = cmp_direct_order;
            if (op_ff == OP_MOD || op_ff == OP_FACT) begin
               rn_in = an_ff;
               rd_in = ad_ff;
            end
         end
         S_MUL: begin
            if (ub_ff[0]) uacc_in = uacc_ff + ua_ff;
            ua_in   = ua_ff << 1;
            ub_in   = ub_ff >> 1;
            ucnt_in = ucnt_ff + CNT_W'(1);
         end
         S_DIV: begin
            uacc_in = div_ge ? div_diff[W-1:0] : div_rem2[W-1:0];
            ua_in   = {ua_ff[W-2:0], div_ge};
            ucnt_in = ucnt_ff + CNT_W'(1);
         end
         S_M1: p1_in = uacc_ff;
         S_M2: begin
            case (op_ff)
               OP_ADD, OP_SUB: p1_in = p1_ff + uacc_ff;
               OP_CMP:         order_in = cmp_prod_order;
               default: begin rn_in = p1_ff; rd_in = uacc_ff; end
            endcase
         end
         S_M3: begin rn_in = p1_ff; rd_in = uacc_ff; end
         S_RED_BEGIN: begin
            neg_in = rn_ff[W-1];
            mn_in  = rn_mag;
            md_in  = rd_ff;
            if (rd_ff[W-1])      fault_in = FAULT_NEG_DEN;
            else if (rd_ff == '0)
               fault_in = (rn_mag == '0) ? FAULT_ZERO_ZERO : FAULT_NONE;
         end
         S_RED_D1: if (rem_zero) begin mn_in = ua_ff; md_in = W'(1); end
         S_RED_D2: if (rem_zero) begin md_in = ua_ff; mn_in = W'(1); end
         S_RED_TWO: begin
            if (both_even) begin
               mn_in = mn_ff >> 1;
               md_in = md_ff >> 1;
            end else begin
               lim_in   = lim_calc;
               trial_in = TRIAL_W'(3);
            end
         end
         S_RED_TA: begin
            if (rem_zero) tq_in = ua_ff;
            else          trial_in = trial_ff + TRIAL_W'(2);
         end
         S_RED_TB: begin
            // common factor: divide both and try the same divisor again; else try the next odd one
            if (rem_zero) begin mn_in = tq_ff; md_in = ua_ff; end
            else          trial_in = trial_ff + TRIAL_W'(2);
         end
         S_RED_END: begin
            rn_in = neg_ff ? (W'(0) - mn_ff) : mn_ff;
            rd_in = md_ff;
         end
         S_POST: begin
            fault_in = post_fault;
            if (op_ff == OP_FACT && post_fault == FAULT_NONE) begin
               p1_in = W'(1);
               k_in  = K_W'(1);
            end
         end
         S_MOD_END: begin
            rn_in = neg_ff ? (W'(0) - uacc_ff) : uacc_ff;
            rd_in = W'(1);
         end
         S_FACT_LOOP: if (!fact_ok) begin rn_in = p1_ff; rd_in = W'(1); end
         S_FACT_NEXT: begin
            p1_in = uacc_ff;
            k_in  = k_ff + K_W'(1);
         end
         default: ;
      endcase

      // load the shared unit on entry
      if ((state_in == S_MUL || state_in == S_DIV) &&
          state_ff != S_MUL && state_ff != S_DIV) begin
         ua_in   = lx;
         ub_in   = ly;
         uacc_in = '0;
         ucnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;   an_ff <= an_in;   ad_ff <= ad_in;
      bn_ff <= bn_in;   bd_ff <= bd_in;   rn_ff <= rn_in;
      rd_ff <= rd_in;   p1_ff <= p1_in;   mn_ff <= mn_in;
      md_ff <= md_in;   tq_ff <= tq_in;   neg_ff <= neg_in;
      lim_ff <= lim_in; trial_ff <= trial_in; k_ff <= k_in;
      fault_ff <= fault_in; order_ff <= order_in;
      ua_ff <= ua_in;   ub_ff <= ub_in;   uacc_ff <= uacc_in;
      ucnt_ff <= ucnt_in;
   end

   // ---------------- outputs ----------------
   always_comb begin
      req_ch.ready   = (state_ff == S_IDLE);
      rsp_ch.valid   = (state_ff == S_DONE);
      rsp_ch.fault   = fault_ff;
      if (fault_ff != FAULT_NONE) begin
         rsp_ch.res_num = '0;
         rsp_ch.res_den = DATA_W'(1);
         rsp_ch.order   = ORDER_EQ;
      end else begin
         rsp_ch.res_num = DATA_W'($signed(rn_ff));
         rsp_ch.res_den = DATA_W'($signed(rd_ff));
         rsp_ch.order   = order_ff;
      end
   end

`ifndef SYNTH
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request and response sides active together");
   a_unit_runs: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV || state_ff == S_MUL) && !unit_last)
         |=> (state_ff == $past(state_ff)))
      else $error("shared unit left before finishing");
   a_trial_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED_TRIAL) |-> trial_ff[0])
      else $error("even trial divisor");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED_END) |-> (md_ff != '0))
      else $error("reduced denominator is zero");
`endif

endmodule
